/* src/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/krgb_pkg.sv */
// Shared types, constants and kernel arithmetic of the 3x3 RGB filter.
// No dependencies.
`timescale 1ns / 1ps
package krgb_pkg;

   localparam int PIX_W       = 32;
   localparam int SUM_W       = 13;
   localparam int COL_W       = 12;
   localparam int ROW_W       = 16;
   localparam int TOTAL_W     = 23;
   localparam int WCFG_W      = 11;
   localparam int HCFG_W      = 12;
   localparam int WEFF_W      = 13;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam logic [ROW_W-1:0] ROW_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 2'd2;

   typedef enum logic [1:0] {
      MODE_BOX     = 2'd0,
      MODE_GAUSS   = 2'd1,
      MODE_SHARPEN = 2'd2,
      MODE_EMBOSS  = 2'd3
   } mode_type;

   // coefficients, row-major, column 2 newest
   localparam logic signed [4:0] KERNEL [4][9] = '{
      '{ 5'sd1,  5'sd1, 5'sd1,   5'sd1,  5'sd1,  5'sd1,  5'sd1, 5'sd1, 5'sd1 },
      '{ 5'sd1,  5'sd2, 5'sd1,   5'sd2,  5'sd4,  5'sd2,  5'sd1, 5'sd2, 5'sd1 },
      '{ 5'sd0, -5'sd2, 5'sd0,  -5'sd2,  5'sd8, -5'sd2,  5'sd0, -5'sd2, 5'sd0 },
      '{-5'sd2, -5'sd1, 5'sd0,  -5'sd1,  5'sd1,  5'sd1,  5'sd0, 5'sd1, 5'sd2 }
   };

   // box divide: (s * BOX_RECIP) >> BOX_SHIFT is floor(s/9) or one below
   localparam logic [8:0] BOX_RECIP = 9'd455;
   localparam int         BOX_SHIFT = 12;
   localparam logic [11:0] NINE     = 12'd9;

   // one word from the front to the window stage
   typedef struct packed {
      logic             push;      // item enters the window stage
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] pix;
      logic             result;    // item yields a result word
      logic             border;
      logic             frame_end;
      mode_type         mode;
   } front_item_type;

   // one queue entry
   typedef struct packed {
      logic signed [SUM_W-1:0] sum_r;
      logic signed [SUM_W-1:0] sum_g;
      logic signed [SUM_W-1:0] sum_b;
      logic [PIX_W-1:0]        center;
      logic                    border;
      logic                    frame_end;
      mode_type                mode;
   } queue_entry_type;

   function automatic logic signed [SUM_W-1:0] channel_sum(input logic [7:0] px [9],
                                                          input mode_type m);
      logic signed [SUM_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < 9; i++) begin
         acc = acc + $signed({5'b0, px[i]}) * KERNEL[m][i];
      end
      return acc;
   endfunction

endpackage

/* src/krgb_front.sv */
// Front end: configuration registers, frame counters and item classification.
// Depends on krgb_pkg.
`timescale 1ns / 1ps
module krgb_front #(
   parameter int MAX_LINE = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [krgb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [krgb_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                             accept,
   input  logic                             flush_req,
   input  logic [krgb_pkg::PIX_W-1:0]       pix_in,
   output krgb_pkg::front_item_type         item
);
   import krgb_pkg::*;

   localparam logic [WEFF_W-1:0] MAX_W = WEFF_W'(MAX_LINE);

   logic [WCFG_W-1:0]  width_ff, width_in;
   logic [HCFG_W-1:0]  height_ff, height_in;
   mode_type           mode_ff, mode_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [TOTAL_W-1:0] emit_ff, emit_in;

   logic [WEFF_W-1:0]  w_eff, w_eff_in;
   logic [HCFG_W-1:0]  h_eff, h_eff_in;
   logic               clr;
   logic [COL_W-1:0]   col_e;
   logic [ROW_W-1:0]   row_e;
   logic [TOTAL_W-1:0] emit_e, emit_n;
   logic               flush, ignore, wrap;

   function automatic logic [WEFF_W-1:0] eff_width(input logic [WCFG_W-1:0] w);
      logic [WEFF_W-1:0] x;
      x = WEFF_W'(w);
      if (x == '0) x = WEFF_W'(1);
      else if (x > MAX_W) x = MAX_W;
      return x;
   endfunction

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      if (csr_write) begin
         case (csr_index)
            REG_WIDTH:  width_in  = csr_data[WCFG_W-1:0];
            REG_HEIGHT: height_in = csr_data[HCFG_W-1:0];
            REG_MODE:   mode_in   = mode_type'(csr_data[1:0]);
            default:    ;
         endcase
      end
      w_eff_in = eff_width(width_in);
      h_eff_in = (height_in == '0) ? HCFG_W'(1) : height_in;
      total_in = TOTAL_W'(w_eff_in) * TOTAL_W'(h_eff_in);
   end

   always_comb begin
      w_eff  = eff_width(width_ff);
      h_eff  = (height_ff == '0) ? HCFG_W'(1) : height_ff;
      // frame already complete (sizes shrank): start over
      clr    = emit_ff >= total_ff;
      col_e  = clr ? '0 : col_ff;
      row_e  = clr ? '0 : row_ff;
      emit_e = clr ? '0 : emit_ff;

      ignore = flush_req && (row_e < ROW_W'(h_eff));
      flush  = flush_req || (row_e >= ROW_W'(h_eff));

      item.push   = !ignore;
      item.col    = col_e;
      item.pix    = flush ? '0 : pix_in;
      item.mode   = mode_ff;
      item.result = (row_e >= ROW_W'(2)) || (row_e == ROW_W'(1) && col_e != '0);
      // a column at or past a shrunk width counts as right edge
      item.border = (col_e < COL_W'(2)) || (WEFF_W'(col_e) >= w_eff) ||
                    (row_e < ROW_W'(2)) || (row_e >= ROW_W'(h_eff));

      emit_n = emit_e + TOTAL_W'(item.result);
      item.frame_end = item.result && (emit_n >= total_ff);

      wrap = (WEFF_W'(col_e) + WEFF_W'(1)) >= w_eff;

      col_in  = col_ff;
      row_in  = row_ff;
      emit_in = emit_ff;
      if (accept) begin
         if (ignore) begin
            col_in  = col_e;
            row_in  = row_e;
            emit_in = emit_e;
         end else if (item.frame_end) begin
            col_in  = '0;
            row_in  = '0;
            emit_in = '0;
         end else begin
            col_in  = wrap ? '0 : col_e + COL_W'(1);
            row_in  = (wrap && row_e != ROW_MAX) ? row_e + ROW_W'(1) : row_e;
            emit_in = emit_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WCFG_W'(640);
         height_ff <= HCFG_W'(480);
         mode_ff   <= MODE_BOX;
         total_ff  <= TOTAL_W'(640 * 480);
         col_ff    <= '0;
         row_ff    <= '0;
         emit_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         mode_ff   <= mode_in;
         total_ff  <= total_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         emit_ff   <= emit_in;
      end
   end

endmodule

/* src/krgb_window.sv */
// Window stage: two line stores, the 3x3 window and the kernel sums.
// Depends on krgb_pkg.
`timescale 1ns / 1ps
module krgb_window #(
   parameter int MAX_LINE = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  krgb_pkg::front_item_type    item,
   input  logic                        q_full,
   output logic                        busy,
   output logic                        q_push,
   output krgb_pkg::queue_entry_type   q_entry
);
   import krgb_pkg::*;

   localparam int AW = $clog2(MAX_LINE);

   logic [PIX_W-1:0] upper_mem [MAX_LINE];
   logic [PIX_W-1:0] middle_mem [MAX_LINE];

   logic             s1_valid_ff;
   front_item_type   s1_ff;
   logic [PIX_W-1:0] top_rd_ff, mid_rd_ff, top_fw_ff, mid_fw_ff;
   logic             fwd_ff;
   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];
   logic [PIX_W-1:0] top, mid;
   logic [7:0]       ch_r [9], ch_g [9], ch_b [9];
   logic             fire;

   assign fire   = s1_valid_ff && !q_full;
   assign busy   = s1_valid_ff && q_full;
   assign q_push = fire && s1_ff.result;
   assign top    = fwd_ff ? top_fw_ff : top_rd_ff;
   assign mid    = fwd_ff ? mid_fw_ff : mid_rd_ff;

   always_ff @(posedge clock) begin
      if (load) top_rd_ff <= upper_mem[item.col[AW-1:0]];
      if (fire) upper_mem[s1_ff.col[AW-1:0]] <= mid;
   end

   always_ff @(posedge clock) begin
      if (load) mid_rd_ff <= middle_mem[item.col[AW-1:0]];
      if (fire) middle_mem[s1_ff.col[AW-1:0]] <= s1_ff.pix;
   end

   // same column written as it is read: take the new data
   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff     <= item;
         fwd_ff    <= fire && (s1_ff.col[AW-1:0] == item.col[AW-1:0]);
         top_fw_ff <= mid;
         mid_fw_ff <= s1_ff.pix;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]   = win_ff[r*3+1];
         win_in[r*3+1] = win_ff[r*3+2];
      end
      win_in[2] = top;
      win_in[5] = mid;
      win_in[8] = s1_ff.pix;
      for (int i = 0; i < 9; i++) begin
         ch_r[i] = win_in[i][7:0];
         ch_g[i] = win_in[i][15:8];
         ch_b[i] = win_in[i][23:16];
      end
      q_entry.sum_r     = channel_sum(ch_r, s1_ff.mode);
      q_entry.sum_g     = channel_sum(ch_g, s1_ff.mode);
      q_entry.sum_b     = channel_sum(ch_b, s1_ff.mode);
      q_entry.center    = win_ff[5];
      q_entry.border    = s1_ff.border;
      q_entry.frame_end = s1_ff.frame_end;
      q_entry.mode      = s1_ff.mode;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else begin
         if (load) s1_valid_ff <= 1'b1;
         else if (fire) s1_valid_ff <= 1'b0;
         if (fire) win_ff <= win_in;
      end
   end

endmodule

/* src/krgb_queue.sv */
// Short result queue between the window stage and the output stage.
// Depends on krgb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module krgb_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  krgb_pkg::queue_entry_type   push_entry,
   input  logic                        pop,
   output krgb_pkg::queue_entry_type   head,
   output logic                        empty,
   output logic                        full
);
   import krgb_pkg::*;

   queue_entry_type   slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QCNT_W-1:0] count_ff;

   assign head  = slot_ff[rd_ff];
   assign empty = count_ff == '0;
   assign full  = count_ff == QCNT_W'(QUEUE_DEPTH);

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + QPTR_W'(1);
         if (pop)  rd_ff <= rd_ff + QPTR_W'(1);
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `ASSERT_ALWAYS(a_no_overflow, clock, reset, !(push && full && !pop))
   `ASSERT_ALWAYS(a_no_underflow, clock, reset, !(pop && empty))
   `ASSERT_NEXT(a_fill, clock, reset, push && !pop, count_ff == $past(count_ff) + QCNT_W'(1))

endmodule

/* src/krgb_back.sv */
// Output stage: divides or clamps the kernel sums (a border pixel passes its center through) and holds the result word.
// Depends on krgb_pkg.
`timescale 1ns / 1ps
module krgb_back (
   input  logic                       clock,
   input  logic                       reset,
   input  krgb_pkg::queue_entry_type  head,
   input  logic                       empty,
   output logic                       pop,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_out_red,
   output logic [7:0]                 rsp_out_green,
   output logic [7:0]                 rsp_out_blue,
   output logic [7:0]                 rsp_out_alpha,
   output logic                       rsp_frame_end
);
   import krgb_pkg::*;

   logic       valid_ff;
   logic [7:0] red_ff, green_ff, blue_ff, alpha_ff;
   logic       fe_ff;
   logic [7:0] red_n, green_n, blue_n;

   function automatic logic [7:0] finish(input logic signed [SUM_W-1:0] s,
                                         input mode_type m);
      logic [11:0] u;
      logic [20:0] prod;
      logic [7:0]  q;
      logic [11:0] rem;
      u    = s[11:0];
      prod = 21'(u) * 21'(BOX_RECIP);
      q    = prod[BOX_SHIFT+7:BOX_SHIFT];
      rem  = u - 12'(q) * NINE;
      case (m)
         MODE_BOX:   return (rem >= NINE) ? q + 8'd1 : q;
         MODE_GAUSS: return u[11:4];
         default: begin
            if (s < 0) return 8'd0;
            else if (s > SUM_W'(255)) return 8'hFF;
            else return s[7:0];
         end
      endcase
   endfunction

   assign pop = !empty && (!valid_ff || !rsp_stall);

   always_comb begin
      if (head.border) begin
         red_n   = head.center[7:0];
         green_n = head.center[15:8];
         blue_n  = head.center[23:16];
      end else begin
         red_n   = finish(head.sum_r, head.mode);
         green_n = finish(head.sum_g, head.mode);
         blue_n  = finish(head.sum_b, head.mode);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         red_ff   <= red_n;
         green_ff <= green_n;
         blue_ff  <= blue_n;
         alpha_ff <= head.center[31:24];
         fe_ff    <= head.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_red   = red_ff;
   assign rsp_out_green = green_ff;
   assign rsp_out_blue  = blue_ff;
   assign rsp_out_alpha = alpha_ff;
   assign rsp_frame_end = fe_ff;

endmodule

/* src/kernel_3x3_rgb_convolution.sv */
// Top level of the streaming 3x3 RGB convolution filter.
// Depends on krgb_pkg, krgb_front, krgb_window, krgb_queue and krgb_back.
//
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_type, req_in_red/green/blue/alpha
// rsp     | out       | rsp_valid/rsp_stall  | rsp_out_red/green/blue/alpha, rsp_frame_end
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One word per clock sustained while rsp is not stalled. The word completing a window
// passes the line store read at the taking edge, then the queue write, then the
// output register load, which raises rsp_valid; a full queue or rsp_stall can hold it.
// The line store read port sets this: one read and one write per column a cycle.
// Reset is synchronous; the line stores are not cleared (never-written entries
// only reach window taps that no result uses). csr_ready is always high.
// A stall on rsp fills the four-entry queue first, then stalls req.
`timescale 1ns / 1ps
module kernel_3x3_rgb_convolution #(
   parameter int MAX_LINE = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [7:0]                       req_in_red,
   input  logic [7:0]                       req_in_green,
   input  logic [7:0]                       req_in_blue,
   input  logic [7:0]                       req_in_alpha,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_out_red,
   output logic [7:0]                       rsp_out_green,
   output logic [7:0]                       rsp_out_blue,
   output logic [7:0]                       rsp_out_alpha,
   output logic                             rsp_frame_end,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [krgb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [krgb_pkg::CSR_DATA_W-1:0]  csr_data
);
   import krgb_pkg::*;

   front_item_type  item;
   queue_entry_type q_entry, q_head;
   logic            accept, busy, q_push, q_pop, q_empty, q_full;

   assign csr_ready = 1'b1;
   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   // counters and classification of each accepted word
   krgb_front #(.MAX_LINE(MAX_LINE)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (accept),
      .flush_req (req_type),
      .pix_in    ({req_in_alpha, req_in_blue, req_in_green, req_in_red}),
      .item      (item)
   );

   // line stores, window shift and kernel sums
   krgb_window #(.MAX_LINE(MAX_LINE)) u_window (
      .clock   (clock),
      .reset   (reset),
      .load    (accept && item.push),
      .item    (item),
      .q_full  (q_full),
      .busy    (busy),
      .q_push  (q_push),
      .q_entry (q_entry)
   );

   krgb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   // divide / clamp and the output register
   krgb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (q_head),
      .empty         (q_empty),
      .pop           (q_pop),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

/* tb/kernel_3x3_rgb_convolution_tb.sv */
// Self-checking testbench for the streaming 3x3 RGB convolution filter.
// Depends on krgb_pkg and kernel_3x3_rgb_convolution; needs no other file.
`timescale 1ns / 1ps
module kernel_3x3_rgb_convolution_tb;
   import krgb_pkg::*;

   localparam int LINE_MAX = 1024;

   // one filtered pixel as it leaves the block
   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
   } pixel_out_type;

   // Predicts filtered pixels from accepted input words and holds them in
   // order until the block hands them out.
   class filter_scoreboard;
      logic [10:0] width_reg;
      logic [11:0] height_reg;
      mode_type    mode_reg;
      logic [31:0] upper_line [LINE_MAX];
      logic [31:0] middle_line [LINE_MAX];
      logic [31:0] win [9];
      int unsigned col_pos, row_pos, emitted;
      pixel_out_type pending [$];
      int errors;
      int results;
      int frames;

      function void reset_state();
         width_reg = 11'd640;
         height_reg = 12'd480;
         mode_reg = MODE_BOX;
         foreach (upper_line[i]) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         col_pos = 0;
         row_pos = 0;
         emitted = 0;
         pending.delete();
         errors = 0;
         results = 0;
         frames = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_WIDTH:  width_reg = data[10:0];
            REG_HEIGHT: height_reg = data[11:0];
            REG_MODE:   mode_reg = mode_type'(data[1:0]);
            default: ;
         endcase
      endfunction

      function int unsigned eff_width();
         int unsigned w;
         w = width_reg;
         if (w == 0) w = 1;
         if (w > LINE_MAX) w = LINE_MAX;
         return w;
      endfunction

      function int unsigned eff_height();
         return (height_reg == 0) ? 1 : height_reg;
      endfunction

      // true while the current frame still takes pixel words
      function bit taking_pixels();
         return row_pos < eff_height();
      endfunction

      function logic [7:0] convolve(int shift);
         int acc, k;
         int coef [9];
         case (mode_reg)
            MODE_BOX:     coef = '{1, 1, 1, 1, 1, 1, 1, 1, 1};
            MODE_GAUSS:   coef = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
            MODE_SHARPEN: coef = '{0, -2, 0, -2, 8, -2, 0, -2, 0};
            default:      coef = '{-2, -1, 0, -1, 1, 1, 0, 1, 2};
         endcase
         acc = 0;
         for (k = 0; k < 9; k++) acc += int'((win[k] >> shift) & 32'hFF) * coef[k];
         case (mode_reg)
            MODE_BOX:   return 8'(acc / 9);
            MODE_GAUSS: return 8'(acc / 16);
            default:    return (acc < 0) ? 8'd0 : (acc > 255) ? 8'd255 : acc[7:0];
         endcase
      endfunction

      // accepted input word; returns 1 when it closes a frame
      function bit note_word(logic flush_in, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, logic [7:0] a);
         int unsigned w, h, total, c, rr, px, py;
         logic [31:0] top, mid, pix, old_center, center;
         bit flush, has_result, border;
         pixel_out_type res;
         w = eff_width();
         h = eff_height();
         total = w * h;
         flush = flush_in;
         center = '0;
         border = 1;
         if (emitted >= total) begin
            col_pos = 0; row_pos = 0; emitted = 0;
         end
         if (flush && row_pos < h) return 0;   // early flush is dropped
         if (row_pos >= h) flush = 1;          // late pixel drains like a flush
         pix = flush ? 32'h0 : {a, b, g, r};
         c = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
         rr = row_pos;
         top = upper_line[c];
         mid = middle_line[c];
         upper_line[c] = mid;
         middle_line[c] = pix;
         old_center = win[5];
         for (int i = 0; i < 3; i++) begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
         end
         win[2] = top;
         win[5] = mid;
         win[8] = pix;
         has_result = (rr >= 2) || (rr == 1 && c >= 1);
         if (has_result) begin
            if (c == 0) center = old_center;
            else begin
               px = c - 1;
               py = rr - 1;
               center = win[4];
               border = (px < 1) || (px + 1 >= w) || (py < 1) || (py + 1 >= h);
            end
         end
         if (c + 1 >= w) begin
            col_pos = 0;
            if (row_pos < 32'hFFFF) row_pos++;
         end else col_pos = c + 1;
         if (!has_result) return 0;
         if (border) begin
            res.red = center[7:0];
            res.green = center[15:8];
            res.blue = center[23:16];
         end else begin
            res.red = convolve(0);
            res.green = convolve(8);
            res.blue = convolve(16);
         end
         res.alpha = center[31:24];
         emitted++;
         res.last = (emitted >= total);
         pending.push_back(res);
         if (res.last) begin
            col_pos = 0; row_pos = 0; emitted = 0;
            frames++;
         end
         return res.last;
      endfunction

      function void check_word(pixel_out_type got);
         pixel_out_type exp;
         results++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result word r=%0d g=%0d b=%0d a=%0d last=%0d",
                     $time, got.red, got.green, got.blue, got.alpha, got.last);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.red !== exp.red)
            $display("%0t: red expected %0d actual %0d", $time, exp.red, got.red);
         if (got.green !== exp.green)
            $display("%0t: green expected %0d actual %0d", $time, exp.green, got.green);
         if (got.blue !== exp.blue)
            $display("%0t: blue expected %0d actual %0d", $time, exp.blue, got.blue);
         if (got.alpha !== exp.alpha)
            $display("%0t: alpha expected %0d actual %0d", $time, exp.alpha, got.alpha);
         if (got.last !== exp.last)
            $display("%0t: frame_end expected %0d actual %0d", $time, exp.last, got.last);
         if (got.red !== exp.red || got.green !== exp.green || got.blue !== exp.blue ||
             got.alpha !== exp.alpha || got.last !== exp.last)
            errors++;
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_stall;
   logic                  req_type = 0;
   logic [7:0]            req_in_red = 0, req_in_green = 0, req_in_blue = 0, req_in_alpha = 0;
   logic                  rsp_valid;
   logic                  rsp_stall = 0;
   logic [7:0]            rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;
   logic                  rsp_frame_end;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   filter_scoreboard sb = new();
   bit no_idle = 0;        // both sides run flat out while set
   bit hold_output = 0;    // receiver holds off for a long stretch
   int words_sent = 0;

   always #2 clock = ~clock;

   kernel_3x3_rgb_convolution dut (.*);

   // result side: compare every word taken
   always @(posedge clock) begin
      pixel_out_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.red = rsp_out_red;
         got.green = rsp_out_green;
         got.blue = rsp_out_blue;
         got.alpha = rsp_out_alpha;
         got.last = rsp_frame_end;
         sb.check_word(got);
      end
   end

   // result side stall pattern; a long hold lets the queue fill and back up req
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = no_idle ? 0 : $urandom_range(0, 4);
         if (hold_output) begin
            n = 300;
            hold_output = 0;
         end
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   // block must be idle before the registers change
   task automatic wait_drained();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic setup_frame(int w, int h, mode_type m);
      wait_drained();
      write_csr(REG_WIDTH, CSR_DATA_W'(w));
      write_csr(REG_HEIGHT, CSR_DATA_W'(h));
      write_csr(REG_MODE, CSR_DATA_W'(m));
      csr_valid <= 0;
   endtask

   // offer one word and wait until taken; returns 1 when the frame closed
   task automatic send_word(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] a, output bit closed);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= kind;
      req_in_red <= r;
      req_in_green <= g;
      req_in_blue <= b;
      req_in_alpha <= a;
      do @(posedge clock); while (req_stall);
      words_sent++;
      closed = sb.note_word(kind, r, g, b, a);
   endtask

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // a whole frame of random pixels, some stray flushes, then drain words
   task automatic run_frame();
      bit closed;
      closed = 0;
      while (!closed) begin
         if (sb.taking_pixels()) begin
            if ($urandom_range(0, 9) == 0)
               send_word(1'b1, rand_chan(), rand_chan(), rand_chan(), rand_chan(), closed);
            else
               send_word(1'b0, rand_chan(), rand_chan(), rand_chan(), rand_chan(), closed);
         end else
            // late pixels drain exactly like flush words
            send_word($urandom_range(0, 2) != 0, rand_chan(), rand_chan(), rand_chan(),
                      rand_chan(), closed);
      end
   endtask

   // a few pixel words of a frame that is left unfinished
   task automatic run_pixels(int n);
      bit closed;
      for (int i = 0; i < n; i++)
         send_word(1'b0, rand_chan(), rand_chan(), rand_chan(), rand_chan(), closed);
   endtask

   // directed: 3x3 frame of alternating extremes to hit both clamp limits
   task automatic run_checker_frame();
      bit closed;
      int k;
      closed = 0;
      k = 0;
      while (!closed) begin
         if (sb.taking_pixels()) begin
            if (k == 4) send_word(1'b1, 8'd1, 8'd2, 8'd3, 8'd4, closed);
            send_word(1'b0, k[0] ? 8'd255 : 8'd0, k[0] ? 8'd0 : 8'd255,
                      k[1] ? 8'd255 : 8'd0, k[0] ? 8'd170 : 8'd85, closed);
         end else
            send_word(1'b0, 8'd7, 8'd7, 8'd7, 8'd7, closed);
         k++;
      end
   endtask

   initial begin
      int w, h;
      sb.reset_state();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: a small 3x3 frame of extremes for the sharpen and emboss kernels
      setup_frame(3, 3, MODE_SHARPEN);
      run_checker_frame();
      setup_frame(3, 3, MODE_EMBOSS);
      run_checker_frame();

      // size extremes: zero width and height fold to one, oversize width clamps,
      // then the wide frame is resized mid-line and finished at the small size
      setup_frame(0, 0, MODE_BOX);
      run_frame();
      setup_frame(12'hFFF, 2, MODE_GAUSS);
      run_pixels(12);
      setup_frame(5, 4, MODE_GAUSS);
      run_frame();

      // long receiver hold while the sender keeps offering
      setup_frame(8, 8, MODE_EMBOSS);
      hold_output = 1;
      no_idle = 1;
      run_frame();
      no_idle = 0;

      while (words_sent < 1750) begin
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
         setup_frame(w, h, mode_type'($urandom_range(0, 3)));
         no_idle = ($urandom_range(0, 4) == 0);
         run_frame();
         no_idle = 0;
      end
      req_valid <= 0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.pending.size() != 0) sb.errors++;
      $display("covered %0d frames, %0d input words, %0d result words, all four kernels",
               sb.frames, words_sent, sb.results);
      $display("size extremes, a mid-line resize and a long output hold backing up input");
      if (sb.errors == 0)
         $display("kernel_3x3_rgb_convolution_tb passed");
      else
         $display("kernel_3x3_rgb_convolution_tb failed");
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #4_000_000;
      $display("kernel_3x3_rgb_convolution_tb failed");
      $finish;
   end

endmodule
